/* src/pidfd_pkg.sv */
package pidfd_pkg;

    // Fixed field widths
    localparam int IN_W   = 24;             // target / measured, signed
    localparam int ERR_W  = IN_W + 1;       // error is one bit wider
    localparam int COEF_W = 32;             // coefficient registers, signed
    localparam int NUM_COEFS = 6;
    localparam int IDX_W  = 3;              // config register index width

    // Config register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_OUT_COEF_1  = 3'd0,
        REG_OUT_COEF_2  = 3'd1,
        REG_ERR_COEF_0  = 3'd2,
        REG_ERR_COEF_1  = 3'd3,
        REG_ERR_COEF_2  = 3'd4,
        REG_FF_GAIN     = 3'd5
    } t_reg_idx;

    // Coefficient set, as held in the config registers
    typedef struct packed {
        logic signed [COEF_W-1:0] out_coef_1;
        logic signed [COEF_W-1:0] out_coef_2;
        logic signed [COEF_W-1:0] err_coef_0;
        logic signed [COEF_W-1:0] err_coef_1;
        logic signed [COEF_W-1:0] err_coef_2;
        logic signed [COEF_W-1:0] ff_gain;
    } t_coefs;

endpackage

/* src/pidfd_datapath.sv */
module pidfd_datapath
    import pidfd_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int DRIVE_W   = FRAC_BITS + 2
) (
    input  t_coefs                    i_coefs,
    input  logic signed [IN_W-1:0]    i_target,
    input  logic signed [IN_W-1:0]    i_measured,
    input  logic signed [ERR_W-1:0]   i_error_prev,
    input  logic signed [ERR_W-1:0]   i_error_prev2,
    input  logic signed [DRIVE_W-1:0] i_drive_prev,
    input  logic signed [DRIVE_W-1:0] i_drive_prev2,
    output logic signed [ERR_W-1:0]   o_error,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic                      o_clamped
);

    localparam int HIST_W = (ERR_W > DRIVE_W) ? ERR_W : DRIVE_W;
    // six products plus headroom for the adder tree
    localparam int SUM_W  = COEF_W + HIST_W + 3;
    localparam int PE_W   = COEF_W + ERR_W;
    localparam int PD_W   = COEF_W + DRIVE_W;
    localparam int PT_W   = COEF_W + IN_W;

    localparam logic signed [SUM_W-1:0]   LIM_HI =
        SUM_W'(64'sd1 <<< (2 * FRAC_BITS));
    localparam logic signed [SUM_W-1:0]   LIM_LO = -LIM_HI;
    localparam logic signed [DRIVE_W-1:0] DRIVE_ONE =
        DRIVE_W'(64'sd1 <<< FRAC_BITS);

    logic signed [ERR_W-1:0] error;
    logic signed [PD_W-1:0]  p_u1;
    logic signed [PD_W-1:0]  p_u2;
    logic signed [PE_W-1:0]  p_e0;
    logic signed [PE_W-1:0]  p_e1;
    logic signed [PE_W-1:0]  p_e2;
    logic signed [PT_W-1:0]  p_ff;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_shr;

    // error = target - measured, one bit of growth
    assign error = ERR_W'(i_target) - ERR_W'(i_measured);

    // six independent products
    assign p_u1 = i_coefs.out_coef_1 * i_drive_prev;
    assign p_u2 = i_coefs.out_coef_2 * i_drive_prev2;
    assign p_e0 = i_coefs.err_coef_0 * error;
    assign p_e1 = i_coefs.err_coef_1 * i_error_prev;
    assign p_e2 = i_coefs.err_coef_2 * i_error_prev2;
    assign p_ff = i_coefs.ff_gain    * i_target;

    // exact sum, 2*FRAC_BITS fraction bits
    assign sum = SUM_W'(p_e0) + SUM_W'(p_e1) + SUM_W'(p_e2) + SUM_W'(p_ff)
               - SUM_W'(p_u1) - SUM_W'(p_u2);

    // arithmetic shift floors toward minus infinity
    assign sum_shr = sum >>> FRAC_BITS;

    // clamp to [-1, +1]
    always_comb begin
        priority if (sum >= LIM_HI) begin
            o_drive   = DRIVE_ONE;
            o_clamped = 1'b1;
        end else if (sum <= LIM_LO) begin
            o_drive   = -DRIVE_ONE;
            o_clamped = 1'b1;
        end else begin
            o_drive   = sum_shr[DRIVE_W-1:0];
            o_clamped = 1'b0;
        end
    end

    assign o_error = error;

endmodule

/* src/pid_filtered_derivative_saturating_unit.sv */
// Channel  | Dir | tdata (low bit up)                        | tuser
// ---------+-----+-------------------------------------------+-----------
// s        | in  | target_value[23:0], measured_value[47:24] | -
// m        | out | drive_value[17:0], zero pad to 24 bits    | clamped
// cfg      | in  | i_cfg_index selects one of six coefs      | -
//
// One word in, one word out, one word per cycle sustained unless the
// output stalls. From the input register the six products, the sum and
// the clamp run combinationally into the output register, which drives
// o_m_tvalid; the history registers close the recurrence on the previous
// drives. Reset (synchronous, active low) clears coefs and history. A
// stalled output holds its word; the input register fills behind it.
module pid_filtered_derivative_saturating_unit
    import pidfd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream: target_value, measured_value
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [2*IN_W-1:0]    i_s_tdata,
    // master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [((FRAC_BITS+2+7)/8)*8-1:0] o_m_tdata,  // drive_value, pad
    output logic                 o_m_tuser,               // clamped
    // config write port
    input  logic                 i_cfg_wr_en,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_wdata
);

    localparam int DRIVE_W = FRAC_BITS + 2;
    localparam int TDATA_W = ((DRIVE_W + 7) / 8) * 8;

    t_coefs                    r_coefs;
    logic                      r_in_valid;
    logic signed [IN_W-1:0]    r_target;
    logic signed [IN_W-1:0]    r_measured;
    logic signed [ERR_W-1:0]   r_error_prev;
    logic signed [ERR_W-1:0]   r_error_prev2;
    logic signed [DRIVE_W-1:0] r_drive_prev;
    logic signed [DRIVE_W-1:0] r_drive_prev2;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_clamped;

    logic                      advance;
    logic                      in_take;
    logic signed [ERR_W-1:0]   n_error;
    logic signed [DRIVE_W-1:0] n_drive;
    logic                      n_clamped;

    // handshake: compute when the output slot is free or draining
    assign advance    = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | advance;
    assign in_take    = i_s_tvalid & o_s_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_OUT_COEF_1: r_coefs.out_coef_1 <= i_cfg_wdata;
                REG_OUT_COEF_2: r_coefs.out_coef_2 <= i_cfg_wdata;
                REG_ERR_COEF_0: r_coefs.err_coef_0 <= i_cfg_wdata;
                REG_ERR_COEF_1: r_coefs.err_coef_1 <= i_cfg_wdata;
                REG_ERR_COEF_2: r_coefs.err_coef_2 <= i_cfg_wdata;
                REG_FF_GAIN:    r_coefs.ff_gain    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_target   <= i_s_tdata[IN_W-1:0];
            r_measured <= i_s_tdata[2*IN_W-1:IN_W];
        end
    end

    // difference equation and clamp
    pidfd_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .DRIVE_W   (DRIVE_W)
    ) u_datapath (
        .i_coefs       (r_coefs),
        .i_target      (r_target),
        .i_measured    (r_measured),
        .i_error_prev  (r_error_prev),
        .i_error_prev2 (r_error_prev2),
        .i_drive_prev  (r_drive_prev),
        .i_drive_prev2 (r_drive_prev2),
        .o_error       (n_error),
        .o_drive       (n_drive),
        .o_clamped     (n_clamped)
    );

    // history, updated with each computed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_prev  <= '0;
            r_error_prev2 <= '0;
            r_drive_prev  <= '0;
            r_drive_prev2 <= '0;
        end else if (advance) begin
            r_error_prev  <= n_error;
            r_error_prev2 <= r_error_prev;
            r_drive_prev  <= n_drive;
            r_drive_prev2 <= r_drive_prev;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(unsigned'(r_drive));
    assign o_m_tuser  = r_clamped;

endmodule

/* verif/pid_filtered_derivative_saturating_unit_tb.sv */
module pid_filtered_derivative_saturating_unit_tb;
    import pidfd_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int DRV_W = FRAC_BITS + 2;
    localparam int M_DATA_W = ((DRV_W + 7) / 8) * 8;
    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam longint UNIT_WIDE = longint'(1) << (2 * FRAC_BITS);

    localparam int RAND_PHASES = 10;
    localparam int WORDS_PER_PHASE = 125;
    localparam int PRESSURE_PHASE = 2;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    // indexes past the last coefficient, writes there must be dropped
    localparam logic [IDX_W-1:0] IDX_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_7 = 3'd7;

    localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [DRV_W-1:0] DRIVE_POS_ONE = 18'h10000;
    localparam logic [DRV_W-1:0] DRIVE_NEG_ONE = 18'h30000;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;
    typedef enum int {SET_MAX, SET_MIN, SET_FULL, SET_SMALL, SET_TUNED} coef_set_t;
    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct packed {
        logic [DRV_W-1:0] drive;
        logic             clamped;
    } drive_word_t;

    typedef struct {
        row_kind_t               kind;
        logic [IDX_W-1:0]        idx;
        logic [COEF_W-1:0]       val;
        logic signed [IN_W-1:0]  tgt;
        logic signed [IN_W-1:0]  mes;
        logic                    typed;
        drive_word_t             want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [2*IN_W-1:0]     s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en;
    logic [IDX_W-1:0]      cfg_index;
    logic [COEF_W-1:0]     cfg_wdata;

    // controller shadow: coefficients plus error and drive history
    longint coef_shadow [NUM_COEFS] = '{default: 0};
    longint err_z1 = 0;
    longint err_z2 = 0;
    longint drv_z1 = 0;
    longint drv_z2 = 0;

    drive_word_t expected_q [$];
    stim_row_t   directed_rows [$];

    idle_mode_t idle_mode = IDLE_NONE;
    int phase_no = -1;
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int clamp_hits = 0;
    int coef_sets = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always #2 clk = ~clk;

    pid_filtered_derivative_saturating_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),     // target_value, measured_value
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),     // drive_value, zero pad
        .o_m_tuser  (m_tuser),     // clamped
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    // One controller step: exact sum, clamp to +-1, floor to the drive grid
    function automatic drive_word_t pid_advance(input logic signed [IN_W-1:0] tgt,
                                                input logic signed [IN_W-1:0] mes);
        longint t;
        longint m;
        longint e;
        longint acc;
        longint drv;
        drive_word_t res;
        t = tgt;
        m = mes;
        e = t - m;
        acc = - coef_shadow[REG_OUT_COEF_1] * drv_z1
              - coef_shadow[REG_OUT_COEF_2] * drv_z2
              + coef_shadow[REG_ERR_COEF_0] * e
              + coef_shadow[REG_ERR_COEF_1] * err_z1
              + coef_shadow[REG_ERR_COEF_2] * err_z2
              + coef_shadow[REG_FF_GAIN] * t;
        if (acc >= UNIT_WIDE) begin
            drv = UNIT;
            res.clamped = 1'b1;
        end else if (acc <= -UNIT_WIDE) begin
            drv = -UNIT;
            res.clamped = 1'b1;
        end else begin
            drv = acc >>> FRAC_BITS;
            res.clamped = 1'b0;
        end
        res.drive = drv[DRV_W-1:0];
        err_z2 = err_z1;
        err_z1 = e;
        drv_z2 = drv_z1;
        drv_z1 = drv;
        return res;
    endfunction

    function automatic void row_cfg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, idx: idx, val: val, tgt: '0, mes: '0, typed: 1'b0,
                want: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void row_word(input logic signed [IN_W-1:0] tgt,
                                     input logic signed [IN_W-1:0] mes,
                                     input logic typed,
                                     input logic [DRV_W-1:0] drv,
                                     input logic clp);
        stim_row_t row;
        row = '{kind: ROW_WORD, idx: '0, val: '0, tgt: tgt, mes: mes, typed: typed,
                want: '{drive: drv, clamped: clp}};
        directed_rows.push_back(row);
    endfunction

    // Mostly small samples so the loop stays inside the limits, some full range
    function automatic logic signed [IN_W-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 3))
            0, 1: v = int'($urandom_range(0, 32767)) - 16384;
            2: v = int'($urandom_range(0, (1 << 19) - 1)) - (1 << 18);
            default: v = $urandom;
        endcase
        return v[IN_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] coef_pick(input coef_set_t set, input t_reg_idx slot);
        int v;
        case (set)
            SET_MAX: v = COEF_MAX;
            SET_MIN: v = COEF_MIN;
            SET_FULL: v = $urandom;
            SET_SMALL: v = int'($urandom_range(0, 8191)) - 4096;
            default: begin
                // plausible filtered PID: a1 near -1.x, a2 near 0.x
                case (slot)
                    REG_OUT_COEF_1: v = -(65536 + int'($urandom_range(0, 32768)));
                    REG_OUT_COEF_2: v = $urandom_range(0, 32768);
                    REG_ERR_COEF_0: v = $urandom_range(0, 1 << 17);
                    REG_ERR_COEF_1: v = -int'($urandom_range(0, 1 << 17));
                    REG_ERR_COEF_2: v = $urandom_range(0, 1 << 16);
                    REG_FF_GAIN: v = int'($urandom_range(0, 1 << 15)) - (1 << 14);
                    default: v = 0;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTED)
            $display("drive mismatch at word %0d: %s got %0d want %0d",
                     words_checked, what, got, want);
        mismatches++;
    endtask

    // Let the pipe empty before touching the coefficients
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx < NUM_COEFS)
            coef_shadow[idx] = longint'(signed'(val));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word, with random gaps ahead of it; predict at the accept edge
    task automatic send_word(input logic signed [IN_W-1:0] tgt,
                             input logic signed [IN_W-1:0] mes,
                             input logic typed,
                             input drive_word_t want);
        int gap_pct;
        drive_word_t predicted;
        gap_pct = (idle_mode == IDLE_SRC) ? 49 : (idle_mode == IDLE_BOTH) ? 23 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {mes, tgt};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = pid_advance(tgt, mes);
        expected_q.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // Output side: check accepted words, then pick the next tready
    always @(posedge clk) begin
        drive_word_t got;
        drive_word_t want;
        int stall_pct;
        if (rst_n && m_tvalid && m_tready) begin
            got.drive = m_tdata[DRV_W-1:0];
            got.clamped = m_tuser;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word, drive", $signed(got.drive), 0);
            end else begin
                want = expected_q.pop_front();
                if (got.drive !== want.drive)
                    report_mismatch("drive_value", $signed(got.drive), $signed(want.drive));
                if (got.clamped !== want.clamped)
                    report_mismatch("clamped", got.clamped, want.clamped);
            end
            if (got.clamped) clamp_hits++;
            words_checked++;
        end
        // one long hold so the input side backs up
        if (hold_left == 0 && !hold_done && phase_no == PRESSURE_PHASE && s_tvalid) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        stall_pct = (idle_mode == IDLE_SINK) ? 49 : (idle_mode == IDLE_BOTH) ? 23 : 0;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d words still expected",
                     STALL_LIMIT, expected_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        coef_set_t set;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;

        // all coefficients zero after reset: any input gives zero drive
        row_word(IN_MAX, IN_MIN, 1'b1, '0, 1'b0);
        row_word(IN_MIN, IN_MAX, 1'b1, '0, 1'b0);
        row_cfg(IDX_SPARE_6, COEF_MAX);
        row_cfg(IDX_SPARE_7, COEF_MIN);
        row_word(IN_MAX, '0, 1'b1, '0, 1'b0);
        // unity proportional gain: limits hit exactly at +-1.0
        row_cfg(REG_ERR_COEF_0, 32'h0001_0000);
        row_word(24'sd65535, '0, 1'b1, 18'h0ffff, 1'b0);
        row_word(24'sd65536, '0, 1'b1, DRIVE_POS_ONE, 1'b1);
        row_word('0, 24'sd65536, 1'b1, DRIVE_NEG_ONE, 1'b1);
        row_word('0, 24'sd65537, 1'b1, DRIVE_NEG_ONE, 1'b1);
        row_word('0, 24'sd1, 1'b1, 18'h3ffff, 1'b0);
        row_word(IN_MAX, IN_MIN, 1'b1, DRIVE_POS_ONE, 1'b1);
        row_word(IN_MIN, IN_MAX, 1'b1, DRIVE_NEG_ONE, 1'b1);
        row_word('0, '0, 1'b1, '0, 1'b0);
        // half gain: floor rounds toward minus infinity
        row_cfg(REG_ERR_COEF_0, 32'h0000_8000);
        row_word(24'sd1, '0, 1'b1, '0, 1'b0);
        row_word('0, 24'sd1, 1'b1, 18'h3ffff, 1'b0);
        // every coefficient but err_coef_0 in play, extremes on the drive feedback
        row_cfg(REG_ERR_COEF_0, 32'h0000_0000);
        row_cfg(REG_OUT_COEF_1, COEF_MIN);
        row_cfg(REG_OUT_COEF_2, COEF_MAX);
        row_cfg(REG_ERR_COEF_1, 32'h0000_4000);
        row_cfg(REG_ERR_COEF_2, 32'hffff_c000);
        row_cfg(REG_FF_GAIN, 32'h0000_0100);
        row_word(24'sd100, -24'sd100, 1'b0, '0, 1'b0);
        row_word(IN_MAX, '0, 1'b0, '0, 1'b0);
        row_word(IN_MIN, '0, 1'b0, '0, 1'b0);
        row_word('0, '0, 1'b0, '0, 1'b0);
        row_word(24'sd1, 24'sd1, 1'b0, '0, 1'b0);
        row_word(-24'sd5000, 24'sd3000, 1'b0, '0, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                wait_drained();
                cfg_write(directed_rows[r].idx, directed_rows[r].val);
            end else begin
                send_word(directed_rows[r].tgt, directed_rows[r].mes,
                          directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // random phases: new coefficient set and idle pattern each time
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            phase_no = p;
            idle_mode = idle_mode_t'(p % 4);
            case (p)
                0: set = SET_MAX;
                1: set = SET_MIN;
                default: begin
                    case ($urandom_range(0, 3))
                        0: set = SET_FULL;
                        1: set = SET_SMALL;
                        default: set = SET_TUNED;
                    endcase
                end
            endcase
            for (int i = 0; i < NUM_COEFS; i++)
                cfg_write(IDX_W'(i), coef_pick(set, t_reg_idx'(i)));
            coef_sets++;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(rand_sample(), rand_sample(), 1'b0, '0);
        end

        wait_drained();
        $display("covered %0d words (%0d directed rows) over %0d random coefficient sets,",
                 words_sent, directed_rows.size(), coef_sets);
        $display("four idle patterns and a long output hold; %0d of %0d words clamped",
                 clamp_hits, words_checked);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
